>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
// CALQ_ASSERT checks a property outside reset; CALQ_ASSERT_RST checks it always.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CALQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define CALQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/calq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar queue package
// Types, constants and codes shared by the calendar queue scheduler.
// ----------------------------------------------------------------------------
package calq_pkg;

  localparam int TIME_W   = 48;
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 16;
  localparam int NSL_W    = 6;
  localparam int STAT_W   = 3;
  localparam int DIV_DW   = TIME_W + NSL_W;
  localparam int CNT_W    = 10;
  localparam int SAFETY_MUL = 10;

  localparam int WHEEL_SLOTS_DEF  = 32;
  localparam int BUCKET_DEPTH_DEF = 8;
  localparam int ACTIVE_RST       = 32;
  localparam int SPAN_RST         = 131072;

  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_POP      = 1'b1;

  localparam logic REG_ACTIVE_SLOTS = 1'b0;
  localparam logic REG_WHEEL_SPAN   = 1'b1;

  localparam logic [STAT_W-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_POPPED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE      = 3'd3;
  localparam logic [STAT_W-1:0] ST_SAFETY    = 3'd4;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] event_time;
    logic [WORD_W-1:0] local_time;
    logic [WORD_W-1:0] event_handle;
    logic [KIND_W-1:0] event_kind;
    logic [WORD_W-1:0] event_id;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] popped_time;
    logic [WORD_W-1:0] popped_internal;
    logic [WORD_W-1:0] popped_handle;
    logic [KIND_W-1:0] popped_kind;
    logic [WORD_W-1:0] popped_id;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [WORD_W-1:0] internal;
    logic [WORD_W-1:0] handle;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    DIV_T_SPAN,
    DIV_R_SPAN,
    DIV_D_SPAN,
    DIV_Q_N
  } div_op_e;

  typedef enum logic [4:0] {
    IDLE, S_MOD, S_MOD_W, S_SLOT, S_SLOT_W, S_FILL, S_INS_RD, S_INS_CMP,
    P_BND, P_BND_W, P_BMOD, P_BMOD_W, P_RD, P_CHK, P_SH_RD, P_SH_WR, FIN
  } state_e;

  typedef struct packed {
    logic              load;
    logic              div_go;
    div_op_e           div_op;
    logic              slot_set;
    logic              k_load;
    logic              rd_ins;
    logic              wr_up;
    logic              wr_new;
    logic              bslot_set;
    logic              rd_head;
    logic              take_pop;
    logic              advance;
    logic              rd_next;
    logic              wr_dn;
    logic              pop_fin;
    logic              set_st;
    logic [STAT_W-1:0] st_code;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic div_done;
    logic full;
    logic k_zero;
    logic rd_gt;
    logic head_hit;
    logic at_bound;
    logic over;
    logic more;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/calq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar queue divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module calq_div import calq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_DW-1:0] quot_o,
  output logic [WORD_W-1:0] rem_o
);

  localparam int CW = $clog2(DIV_DW + 1);

  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [DIV_DW-1:0] quo_q;
  logic [WORD_W-1:0] rem_q, dvs_q;
  logic [WORD_W:0]   sh;
  logic              ge;

  assign sh = {rem_q, quo_q[DIV_DW-1]};
  assign ge = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_DW-2:0], ge};
      rem_q <= ge ? WORD_W'(sh - {1'b0, dvs_q}) : sh[WORD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/calq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar queue datapath
// Bucket store, fill counts, window, divider and the result register.
// ----------------------------------------------------------------------------
module calq_dp import calq_pkg::*; #(
  parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  input  item_t             in_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output result_t           out_o
);

  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = $clog2(WHEEL_SLOTS * BUCKET_DEPTH);
  localparam int MD = WHEEL_SLOTS * BUCKET_DEPTH;

  function automatic logic [AW-1:0] addr(input logic [SW-1:0] s, input int k);
    return AW'(int'(s) * BUCKET_DEPTH + k);
  endfunction

  logic [NSL_W-1:0]  active_q;
  logic [WORD_W-1:0] span_q;
  logic [NSL_W-1:0]  n;
  logic [WORD_W-1:0] span;
  item_t             item_q;
  logic [SW-1:0]     slot_q, cur_q, bslot_q;
  logic              bvalid_q;
  logic [FW-1:0]     k_q;
  logic [FW-1:0]     fill_q [WHEEL_SLOTS];
  logic [TIME_W-1:0] ws_q, we_q;
  logic [CNT_W-1:0]  cnt_q;
  entry_t            mem [MD];
  entry_t            rd_q;
  result_t           res_q, out_q;
  logic              out_valid_q;
  logic              bge;
  logic [TIME_W-1:0] diff;
  logic [DIV_DW-1:0] dvd;
  logic [WORD_W-1:0] dvs;
  logic              div_done;
  logic [DIV_DW-1:0] quot;
  logic [WORD_W-1:0] rem;
  logic [CNT_W-1:0]  safety;

  assign n      = (active_q == '0) ? NSL_W'(1) :
                  ((int'(active_q) > WHEEL_SLOTS) ? NSL_W'(WHEEL_SLOTS) : active_q);
  assign span   = (span_q == '0) ? WORD_W'(1) : span_q;
  assign safety = CNT_W'(int'(n) * SAFETY_MUL);
  assign bge    = item_q.event_time >= ws_q;
  assign diff   = bge ? item_q.event_time - ws_q : ws_q - item_q.event_time;

  always_comb begin
    dvs = span;
    case (cmd_i.div_op)
      DIV_T_SPAN: dvd = DIV_DW'(item_q.event_time);
      DIV_R_SPAN: dvd = DIV_DW'(rem) * DIV_DW'(n);
      DIV_D_SPAN: dvd = DIV_DW'(diff) * DIV_DW'(n);
      default: begin
        dvd = quot;
        dvs = WORD_W'(n);
      end
    endcase
  end

  calq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Configuration and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= NSL_W'(ACTIVE_RST);
      span_q      <= WORD_W'(SPAN_RST);
      cur_q       <= '0;
      ws_q        <= '0;
      we_q        <= TIME_W'(SPAN_RST);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WHEEL_SLOTS; i++) fill_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ACTIVE_SLOTS: active_q <= cfg_wdata_i[NSL_W-1:0];
          REG_WHEEL_SPAN:   span_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) cnt_q <= '0;
      if (cmd_i.advance) begin
        cnt_q <= cnt_q + 1'b1;
        if (int'(cur_q) + 1 >= int'(n)) begin
          cur_q <= '0;
          ws_q  <= we_q;
          we_q  <= we_q + TIME_W'(span);
        end else begin
          cur_q <= cur_q + 1'b1;
        end
      end
      if (cmd_i.wr_new)  fill_q[slot_q] <= fill_q[slot_q] + 1'b1;
      if (cmd_i.pop_fin) fill_q[cur_q]  <= fill_q[cur_q] - 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Item, walk registers and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      res_q  <= '0;
    end
    if (cmd_i.slot_set) slot_q <= SW'(quot);
    if (cmd_i.bslot_set) begin
      bslot_q  <= bge ? SW'(rem) : '0;
      bvalid_q <= bge || (rem == '0);
    end
    if (cmd_i.k_load) k_q <= fill_q[slot_q];
    if (cmd_i.wr_up) k_q <= k_q - 1'b1;
    if (cmd_i.wr_dn) k_q <= k_q + 1'b1;
    if (cmd_i.set_st) res_q.status <= cmd_i.st_code;
    if (cmd_i.take_pop) begin
      k_q                   <= '0;
      res_q.popped_time     <= rd_q.tm;
      res_q.popped_internal <= rd_q.internal;
      res_q.popped_handle   <= rd_q.handle;
      res_q.popped_kind     <= rd_q.kind;
      res_q.popped_id       <= rd_q.id;
    end
    if (cmd_i.out_load) out_q <= res_q;
  end

  // Bucket store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ins)       rd_q <= mem[addr(slot_q, int'(k_q) - 1)];
    else if (cmd_i.rd_head) rd_q <= mem[addr(cur_q, 0)];
    else if (cmd_i.rd_next) rd_q <= mem[addr(cur_q, int'(k_q) + 1)];
    if (cmd_i.wr_up) mem[addr(slot_q, int'(k_q))] <= rd_q;
    else if (cmd_i.wr_new)
      mem[addr(slot_q, int'(k_q))] <= '{tm: item_q.event_time,
                                       internal: item_q.local_time,
                                       handle: item_q.event_handle,
                                       kind: item_q.event_kind,
                                       id: item_q.event_id};
    else if (cmd_i.wr_dn) mem[addr(cur_q, int'(k_q))] <= rd_q;
  end

  always_comb begin
    sts_o.action   = in_i.action;
    sts_o.div_done = div_done;
    sts_o.full     = int'(fill_q[slot_q]) >= BUCKET_DEPTH;
    sts_o.k_zero   = k_q == '0;
    sts_o.rd_gt    = rd_q.tm > item_q.event_time;
    sts_o.head_hit = (fill_q[cur_q] != '0) && (rd_q.tm <= item_q.event_time);
    sts_o.at_bound = bvalid_q && (cur_q == bslot_q) && (item_q.event_time < we_q);
    sts_o.over     = cnt_q > safety;
    sts_o.more     = int'(k_q) + 1 < int'(fill_q[cur_q]);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/calq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar queue controller
// Sequences slot hashing, bucket insertion and the pop walk.
// ----------------------------------------------------------------------------
module calq_ctrl import calq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (sts_i.action == ACT_POP) ? P_BND : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_T_SPAN;
        state_d = S_MOD_W;
      end
      S_MOD_W: if (sts_i.div_done) state_d = S_SLOT;
      S_SLOT: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_R_SPAN;
        state_d = S_SLOT_W;
      end
      S_SLOT_W: begin
        if (sts_i.div_done) begin
          cmd_o.slot_set = 1'b1;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (sts_i.full) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = ST_DROPPED;
          state_d = FIN;
        end else begin
          cmd_o.k_load = 1'b1;
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (sts_i.k_zero) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = ST_SCHEDULED;
          state_d = FIN;
        end else begin
          cmd_o.rd_ins = 1'b1;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.rd_gt) begin
          cmd_o.wr_up = 1'b1;
          state_d = S_INS_RD;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = ST_SCHEDULED;
          state_d = FIN;
        end
      end
      P_BND: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_D_SPAN;
        state_d = P_BND_W;
      end
      P_BND_W: if (sts_i.div_done) state_d = P_BMOD;
      P_BMOD: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = DIV_Q_N;
        state_d = P_BMOD_W;
      end
      P_BMOD_W: begin
        if (sts_i.div_done) begin
          cmd_o.bslot_set = 1'b1;
          state_d = P_RD;
        end
      end
      P_RD: begin
        if (sts_i.over) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = ST_SAFETY;
          state_d = FIN;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d = P_CHK;
        end
      end
      P_CHK: begin
        if (sts_i.head_hit) begin
          cmd_o.take_pop = 1'b1;
          cmd_o.set_st   = 1'b1;
          cmd_o.st_code  = ST_POPPED;
          state_d = P_SH_RD;
        end else if (sts_i.at_bound) begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = ST_NONE;
          state_d = FIN;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = P_RD;
        end
      end
      P_SH_RD: begin
        if (sts_i.more) begin
          cmd_o.rd_next = 1'b1;
          state_d = P_SH_WR;
        end else begin
          cmd_o.pop_fin = 1'b1;
          state_d = FIN;
        end
      end
      P_SH_WR: begin
        cmd_o.wr_dn = 1'b1;
        state_d = P_SH_RD;
      end
      FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

endmodule

>>> rtl/calendar_queue_event_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar queue event scheduler
// Schedules timed events into wheel buckets and pops the earliest due one.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one beat per operation. A schedule beat
// (action 0) hashes the event time onto a slot and inserts the event into
// that slot's sorted bucket; a pop beat (action 1) walks the wheel from the
// current slot looking for an event due at or before the given bound.
// Every input beat produces exactly one output beat carrying a status code
// and, for a successful pop, the event's fields (zero otherwise).
// Each operation runs two passes of a bit-serial divider, then a bucket
// pass. Scheduling adds a read and a compare step per entry moved; popping
// adds a read and a check step per slot visited and a read and a write step
// per entry moved. One operation is in flight at a time.
// The result sits in an output register; the next beat may be accepted while
// it waits, and the block only stalls once a second result is ready.
// Reset clears all bucket fill counts, the current slot and the window, and
// loads the register defaults. Configuration writes take effect at once and
// should only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_queue_event_scheduler import calq_pkg::*; #(
  parameter int WHEEL_SLOTS  = WHEEL_SLOTS_DEF,
  parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_o
);

  // Command and status bundles between sequencer and datapath.
  cmd_t cmd;
  sts_t sts;

  calq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  calq_dp #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // An accepted beat keeps the input closed until its result is produced.
  `CALQ_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o,
    "input accepted while an operation is in flight")

  // The result register is never overwritten while its beat is stalled.
  `CALQ_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd.out_load |-> !sts.out_busy,
    "result loaded over a stalled beat")

  // Only a successful pop carries event fields.
  `CALQ_ASSERT(a_zero_fields, clk_i, rst_ni,
    out_valid_o && (out_o.status != ST_POPPED) |->
      (out_o.popped_time == '0) && (out_o.popped_id == '0) && (out_o.popped_kind == '0),
    "event fields set on a non-pop result")

  // No result is presented while reset is held.
  `CALQ_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o,
    "output valid during reset")

endmodule
